// ===== sv/cpc_pkg.sv =====
// shared types, constants and fixed-point helpers for the circle pair collision block
// no dependencies
package cpc_pkg;

   localparam int FRAC_BITS = 16;

   // signed width that holds any shifted 64 bit product plus its sign
   localparam int PW = 66 - FRAC_BITS;

   // front/back queue
   localparam int QDEPTH = 4;
   localparam int QAW    = 2;

   // back pipeline stage map
   localparam int SQ_STEPS  = 32;
   localparam int ST_OV     = SQ_STEPS;
   localparam int DIV_STEPS = 31;
   localparam int ST_DIV0   = ST_OV + 1;
   localparam int ST_PM     = ST_DIV0 + DIV_STEPS;
   localparam int ST_VN     = ST_PM + 1;
   localparam int ST_SW     = ST_VN + 1;
   localparam int ST_TM     = ST_SW + 1;
   localparam int ST_FIN    = ST_TM + 1;
   localparam int NSTAGE    = ST_FIN + 1;

   localparam logic [FRAC_BITS:0] HALF_W = (FRAC_BITS + 1)'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] first_vx;
      logic signed [31:0] first_vy;
      logic        [30:0] first_radius;
      logic        [30:0] first_mass;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] second_vx;
      logic signed [31:0] second_vy;
      logic        [30:0] second_radius;
      logic        [30:0] second_mass;
   } cpc_req_type;

   typedef struct packed {
      logic               hit;
      logic               coincident;
      logic signed [31:0] new_first_x;
      logic signed [31:0] new_first_y;
      logic signed [31:0] new_first_vx;
      logic signed [31:0] new_first_vy;
      logic signed [31:0] new_second_x;
      logic signed [31:0] new_second_y;
      logic signed [31:0] new_second_vx;
      logic signed [31:0] new_second_vy;
   } cpc_rsp_type;

   // classified pair, front to back
   typedef struct packed {
      cpc_req_type        item;
      logic               hit;
      logic               coin;
      logic        [63:0] d2;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic        [31:0] rsum;
   } cpc_cls_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } cpc_qstat_type;

   // one back pipeline stage
   typedef struct packed {
      cpc_req_type          item;
      logic                 hit;
      logic                 coin;
      logic        [63:0]   d2;
      logic signed [32:0]   dx;
      logic signed [32:0]   dy;
      logic        [31:0]   rsum;
      logic        [33:0]   sq_rem;
      logic        [31:0]   sq_root;
      logic        [31:0]   msum;
      logic        [31:0]   wr1;
      logic        [31:0]   wr2;
      logic [FRAC_BITS:0]   w1;
      logic [FRAC_BITS:0]   w2;
      logic        [63:0]   nx;
      logic        [63:0]   ny;
      logic        [32:0]   drx;
      logic        [32:0]   dry;
      logic        [30:0]   qx;
      logic        [30:0]   qy;
      logic signed [31:0]   px;
      logic signed [31:0]   py;
      logic signed [PW-1:0] ux;
      logic signed [PW-1:0] uy;
      logic signed [31:0]   vn;
      logic signed [32:0]   s1;
      logic signed [32:0]   s2;
      logic signed [PW-1:0] t1x;
      logic signed [PW-1:0] t1y;
      logic signed [PW-1:0] t2x;
      logic signed [PW-1:0] t2y;
      cpc_rsp_type          res;
   } cpc_work_type;

   function automatic logic [31:0] abs33(input logic [32:0] v);
      logic [32:0] n;
      n = v[32] ? (~v + 33'd1) : v;
      return n[31:0];
   endfunction

   function automatic logic [PW-1:0] sx32(input logic [31:0] v);
      return {{(PW - 32){v[31]}}, v};
   endfunction

   // magnitude product shifted down, sign restored
   function automatic logic [PW-1:0] qsign(input logic [63:0] prod, input logic neg);
      logic [63:0]   m;
      logic [PW-1:0] t;
      m = prod >> FRAC_BITS;
      t = m[PW-1:0];
      return neg ? (~t + PW'(1)) : t;
   endfunction

   function automatic logic [31:0] sat32(input logic [PW-1:0] v);
      if (v[PW-1:31] == {(PW - 31){v[PW-1]}}) return v[31:0];
      else if (v[PW-1]) return 32'h8000_0000;
      else return 32'h7fff_ffff;
   endfunction

endpackage

// ===== sv/cpc_front.sv =====
// front end: centre difference, squared distance and contact classification
// depends on cpc_pkg
module cpc_front import cpc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  cpc_req_type   req_data,
   input  cpc_qstat_type qstat,
   output logic          push_valid,
   output cpc_cls_type   push_data
);

   logic               vld1_ff, vld2_ff, vld3_ff;
   cpc_req_type        item1_ff, item2_ff;
   logic signed [32:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   logic        [31:0] ax1_ff, ay1_ff, rsum1_ff, rsum2_ff;
   logic        [63:0] sqx_ff, sqy_ff, rsq_ff;
   cpc_cls_type        cls_ff, cls_in;
   logic               adv;
   logic        [64:0] d2;

   assign adv       = !(vld3_ff && qstat.full);
   assign req_stall = !adv;

   always_comb begin
      d2             = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      cls_in.item    = item2_ff;
      cls_in.d2      = d2[63:0];
      cls_in.dx      = dx2_ff;
      cls_in.dy      = dy2_ff;
      cls_in.rsum    = rsum2_ff;
      cls_in.hit     = !d2[64] && (d2[63:0] <= rsq_ff);
      cls_in.coin    = cls_in.hit && (dx2_ff == '0) && (dy2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= req_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item1_ff <= req_data;
         dx1_ff   <= {req_data.second_x[31], req_data.second_x}
                   - {req_data.first_x[31], req_data.first_x};
         dy1_ff   <= {req_data.second_y[31], req_data.second_y}
                   - {req_data.first_y[31], req_data.first_y};
         ax1_ff   <= abs33({req_data.second_x[31], req_data.second_x}
                         - {req_data.first_x[31], req_data.first_x});
         ay1_ff   <= abs33({req_data.second_y[31], req_data.second_y}
                         - {req_data.first_y[31], req_data.first_y});
         rsum1_ff <= {1'b0, req_data.first_radius} + {1'b0, req_data.second_radius};
         item2_ff <= item1_ff;
         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
         rsum2_ff <= rsum1_ff;
         sqx_ff   <= 64'(ax1_ff) * 64'(ax1_ff);
         sqy_ff   <= 64'(ay1_ff) * 64'(ay1_ff);
         rsq_ff   <= 64'(rsum1_ff) * 64'(rsum1_ff);
         cls_ff   <= cls_in;
      end
   end

   assign push_valid = vld3_ff;
   assign push_data  = cls_ff;

endmodule

// ===== sv/cpc_queue.sv =====
// short queue of classified pairs between front and back
// depends on cpc_pkg
module cpc_queue import cpc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  cpc_cls_type   push_data,
   input  logic          pop,
   output cpc_qstat_type qstat,
   output cpc_cls_type   head
);

   cpc_cls_type       mem_ff [QDEPTH];
   logic [QAW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QAW:0]      cnt_ff;
   logic              push;

   assign qstat.full     = (cnt_ff == (QAW + 1)'(QDEPTH));
   assign qstat.nonempty = (cnt_ff != '0);
   assign push           = push_valid && !qstat.full;
   assign head           = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== sv/cpc_back.sv =====
// back end: square root, push division, mass weights and velocity update pipeline
// depends on cpc_pkg
module cpc_back import cpc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cpc_qstat_type qstat,
   input  cpc_cls_type   head,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output cpc_rsp_type   rsp_data
);

   cpc_work_type              st_ff [NSTAGE];
   cpc_work_type              st_in [NSTAGE];
   cpc_work_type              prv   [NSTAGE];
   cpc_work_type              ld_w;
   logic [NSTAGE-1:0]         vld_ff;
   logic                      adv;

   assign adv = !(vld_ff[NSTAGE-1] && rsp_stall);
   assign pop = qstat.nonempty && adv;

   always_comb begin
      ld_w         = '0;
      ld_w.item    = head.item;
      ld_w.hit     = head.hit;
      ld_w.coin    = head.coin;
      ld_w.d2      = head.d2;
      ld_w.dx      = head.dx;
      ld_w.dy      = head.dy;
      ld_w.rsum    = head.rsum;
      ld_w.msum    = {1'b0, head.item.first_mass} + {1'b0, head.item.second_mass};
      ld_w.wr1     = {2'b00, head.item.second_mass[30:1]};
      ld_w.wr2     = {2'b00, head.item.first_mass[30:1]};
      prv[0]       = ld_w;
      for (int k = 1; k < NSTAGE; k++) prv[k] = st_ff[k-1];
   end

   always_comb begin
      cpc_work_type       w;
      logic [35:0]        sr;
      logic [33:0]        trial;
      logic [32:0]        mr;
      logic               b1, b2;
      logic [33:0]        dr;
      logic [32:0]        dv;
      logic [31:0]        ov, ax, ay, arx, ary, avn, as1, as2, apx, apy, pxm, pym;
      logic signed [32:0] rvx, rvy;
      logic [PW-1:0]      sum, tmp;

      // integer square root, two radicand bits per stage; mass weights alongside
      for (int k = 0; k < SQ_STEPS; k++) begin
         w     = prv[k];
         sr    = {w.sq_rem, w.d2[2*(SQ_STEPS-1-k) +: 2]};
         trial = {w.sq_root, 2'b01};
         if (sr >= {2'b00, trial}) begin
            w.sq_rem  = 34'(sr - {2'b00, trial});
            w.sq_root = {w.sq_root[30:0], 1'b1};
         end else begin
            w.sq_rem  = sr[33:0];
            w.sq_root = {w.sq_root[30:0], 1'b0};
         end
         if (k <= FRAC_BITS) begin
            b1 = (k == 0) ? w.item.second_mass[0] : 1'b0;
            b2 = (k == 0) ? w.item.first_mass[0] : 1'b0;
            mr = {w.wr1, b1};
            if (mr >= {1'b0, w.msum}) begin
               w.wr1 = 32'(mr - {1'b0, w.msum});
               w.w1  = {w.w1[FRAC_BITS-1:0], 1'b1};
            end else begin
               w.wr1 = mr[31:0];
               w.w1  = {w.w1[FRAC_BITS-1:0], 1'b0};
            end
            mr = {w.wr2, b2};
            if (mr >= {1'b0, w.msum}) begin
               w.wr2 = 32'(mr - {1'b0, w.msum});
               w.w2  = {w.w2[FRAC_BITS-1:0], 1'b1};
            end else begin
               w.wr2 = mr[31:0];
               w.w2  = {w.w2[FRAC_BITS-1:0], 1'b0};
            end
         end
         st_in[k] = w;
      end

      // overlap and push numerators
      w     = prv[ST_OV];
      ov    = w.rsum - w.sq_root;
      ax    = abs33(w.dx);
      ay    = abs33(w.dy);
      w.nx  = 64'(ax) * 64'(ov);
      w.ny  = 64'(ay) * 64'(ov);
      w.drx = w.nx[63:31];
      w.dry = w.ny[63:31];
      if (w.msum == '0) begin
         w.w1 = HALF_W;
         w.w2 = HALF_W;
      end
      st_in[ST_OV] = w;

      // push division by twice the distance, one quotient bit per stage
      for (int j = 0; j < DIV_STEPS; j++) begin
         w  = prv[ST_DIV0+j];
         dv = {w.sq_root, 1'b0};
         dr = {w.drx, w.nx[DIV_STEPS-1-j]};
         if (dr >= {1'b0, dv}) begin
            w.drx = 33'(dr - {1'b0, dv});
            w.qx  = {w.qx[29:0], 1'b1};
         end else begin
            w.drx = dr[32:0];
            w.qx  = {w.qx[29:0], 1'b0};
         end
         dr = {w.dry, w.ny[DIV_STEPS-1-j]};
         if (dr >= {1'b0, dv}) begin
            w.dry = 33'(dr - {1'b0, dv});
            w.qy  = {w.qy[29:0], 1'b1};
         end else begin
            w.dry = dr[32:0];
            w.qy  = {w.qy[29:0], 1'b0};
         end
         st_in[ST_DIV0+j] = w;
      end

      // signed push vector and relative velocity products
      w    = prv[ST_PM];
      pxm  = {1'b0, w.qx};
      pym  = {1'b0, w.qy};
      w.px = w.dx[32] ? (~pxm + 32'd1) : pxm;
      w.py = w.dy[32] ? (~pym + 32'd1) : pym;
      rvx  = {w.item.first_vx[31], w.item.first_vx} - {w.item.second_vx[31], w.item.second_vx};
      rvy  = {w.item.first_vy[31], w.item.first_vy} - {w.item.second_vy[31], w.item.second_vy};
      arx  = abs33(rvx);
      ary  = abs33(rvy);
      w.ux = qsign(64'(arx) * 64'(w.qx), rvx[32] ^ w.dx[32]);
      w.uy = qsign(64'(ary) * 64'(w.qy), rvy[32] ^ w.dy[32]);
      st_in[ST_PM] = w;

      // normal velocity
      w    = prv[ST_VN];
      sum  = w.ux + w.uy;
      w.vn = sat32(sum);
      st_in[ST_VN] = w;

      // scaled by mass weights
      w    = prv[ST_SW];
      avn  = abs33({w.vn[31], w.vn});
      tmp  = qsign(64'(avn) * 64'(w.w1), w.vn[31]);
      w.s1 = tmp[32:0];
      tmp  = qsign(64'(avn) * 64'(w.w2), w.vn[31]);
      w.s2 = tmp[32:0];
      st_in[ST_SW] = w;

      // velocity deltas
      w     = prv[ST_TM];
      apx   = abs33({w.px[31], w.px});
      apy   = abs33({w.py[31], w.py});
      as1   = abs33(w.s1);
      as2   = abs33(w.s2);
      w.t1x = qsign(64'(apx) * 64'(as1), w.px[31] ^ w.s1[32]);
      w.t1y = qsign(64'(apy) * 64'(as1), w.py[31] ^ w.s1[32]);
      w.t2x = qsign(64'(apx) * 64'(as2), w.px[31] ^ w.s2[32]);
      w.t2y = qsign(64'(apy) * 64'(as2), w.py[31] ^ w.s2[32]);
      st_in[ST_TM] = w;

      // result selection with saturation
      w                  = prv[ST_FIN];
      w.res.hit          = w.hit;
      w.res.coincident   = w.coin;
      if (w.hit && !w.coin) begin
         w.res.new_first_x   = sat32(sx32(w.item.first_x) - sx32(w.px));
         w.res.new_first_y   = sat32(sx32(w.item.first_y) - sx32(w.py));
         w.res.new_first_vx  = sat32(sx32(w.item.first_vx) - w.t1x);
         w.res.new_first_vy  = sat32(sx32(w.item.first_vy) - w.t1y);
         w.res.new_second_x  = sat32(sx32(w.item.second_x) + sx32(w.px));
         w.res.new_second_y  = sat32(sx32(w.item.second_y) + sx32(w.py));
         w.res.new_second_vx = sat32(sx32(w.item.second_vx) + w.t2x);
         w.res.new_second_vy = sat32(sx32(w.item.second_vy) + w.t2y);
      end else begin
         w.res.new_first_x   = w.item.first_x;
         w.res.new_first_y   = w.item.first_y;
         w.res.new_first_vx  = w.item.first_vx;
         w.res.new_first_vy  = w.item.first_vy;
         w.res.new_second_x  = w.item.second_x;
         w.res.new_second_y  = w.item.second_y;
         w.res.new_second_vx = w.item.second_vx;
         w.res.new_second_vy = w.item.second_vy;
      end
      st_in[ST_FIN] = w;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NSTAGE-2:0], qstat.nonempty};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NSTAGE; k++) st_ff[k] <= st_in[k];
      end
   end

   assign rsp_valid = vld_ff[NSTAGE-1];
   assign rsp_data  = st_ff[NSTAGE-1].res;

endmodule

// ===== sv/circle_pair_collision_resolve.sv =====
// top level of the circle pair collision resolver
// depends on cpc_pkg, cpc_front, cpc_queue, cpc_back
//
// usage
//   req_ channel: one beat carries a pair of particles (signed position and
//   velocity, unsigned radius and mass, fixed point, FRAC_BITS fraction bits)
//   rsp_ channel: one beat per request beat, in order, with hit and
//   coincident flags and the resolved, saturated positions and velocities
//   a beat moves when valid is high and stall is low at a rising clock
// throughput
//   one pair per cycle unless stalled; every step is pipelined, nothing shared
// path
//   rsp_valid rises once the request beat has passed the front stage that
//   takes it, the 2 front stages after it, the queue, 32 square root
//   stages, the overlap multiply, 31 push division stages and 5 multiply /
//   saturate stages
// stalls
//   a stalled result freezes the back pipeline only; the 4-deep queue keeps
//   taking beats from the front until it fills, then req_stall rises
// reset
//   synchronous, active high; clears all valid bits and the queue, payload
//   registers are left as they are
module circle_pair_collision_resolve import cpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  cpc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output cpc_rsp_type rsp_data
);

   cpc_qstat_type qstat;
   logic          f_valid;
   cpc_cls_type   f_data;
   cpc_cls_type   q_head;
   logic          q_pop;

   // classify: differences, squares, contact test
   cpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .qstat      (qstat),
      .push_valid (f_valid),
      .push_data  (f_data)
   );

   // decouples front from back stalls
   cpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_data  (f_data),
      .pop        (q_pop),
      .qstat      (qstat),
      .head       (q_head)
   );

   // resolve: sqrt, push, weights, velocity update
   cpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // coincident centres are always a contact
   a_coin_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hit || !rsp_data.coincident))
      else $error("coincident result without hit");

   // front must hold off new beats while its last stage cannot drain
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      (f_valid && qstat.full) |-> req_stall)
      else $error("front accepted a beat with a blocked queue");

   // back pulls only from a non-empty queue
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> qstat.nonempty)
      else $error("queue popped while empty");

endmodule
